### rtl/bll_pkg.sv
`timescale 1ns / 1ps
// Package for the binary-lifting lowest-common-ancestor engine.
// Holds field widths, request and status codes, sequencer states and table port types.
// No dependencies.
package bll_pkg;

    localparam int NODE_W = 10;
    localparam int LVL_W  = 4;
    localparam int STAT_W = 2;

    localparam logic [NODE_W-1:0] DEPTH_MAX = 10'd1023;
    localparam logic [NODE_W-1:0] ROOT_RESET = 10'd1;

    localparam logic REQ_ATTACH = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ABSENT    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DUPLICATE = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDB,
        ST_ATT_CHK,
        ST_ATT_FILL,
        ST_Q_CHK,
        ST_Q_LIFT,
        ST_Q_DESC,
        ST_Q_FIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [LVL_W-1:0]  level;
    } t_anc_rd;

    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] node;
        logic [LVL_W-1:0]  level;
        logic [NODE_W-1:0] data;
    } t_anc_wr;

endpackage

### rtl/bll_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the lowest-common-ancestor engine: request, response, root write.
// Depends on bll_pkg for field widths.
interface bll_req_if;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [bll_pkg::NODE_W-1:0] node_a;
    logic [bll_pkg::NODE_W-1:0] node_b;

    modport source (output valid, output req_type, output node_a, output node_b, input ready);
    modport sink   (input valid, input req_type, input node_a, input node_b, output ready);
endinterface

interface bll_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [bll_pkg::NODE_W-1:0] ancestor_node;
    logic [bll_pkg::STAT_W-1:0] status;

    modport source (output valid, output ancestor_node, output status, input ready);
    modport sink   (input valid, input ancestor_node, input status, output ready);
endinterface

interface bll_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [bll_pkg::NODE_W-1:0] root_node;

    modport source (output valid, output root_node, input ready);
    modport sink   (input valid, input root_node, output ready);
endinterface

### rtl/bll_anc_table.sv
`timescale 1ns / 1ps
// Ancestor table memory: one write port, two registered read ports, root clamping.
// Depends on bll_pkg for the request structs.
module bll_anc_table #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  logic                       i_clk,
    input  logic [bll_pkg::NODE_W-1:0] i_root,
    input  bll_pkg::t_anc_wr           i_wr,
    input  bll_pkg::t_anc_rd           i_rd0,
    input  bll_pkg::t_anc_rd           i_rd1,
    output logic [bll_pkg::NODE_W-1:0] o_anc0,
    output logic [bll_pkg::NODE_W-1:0] o_anc1
);

    localparam int DEPTH = NODES * LEVELS;
    localparam int TAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [bll_pkg::NODE_W-1:0] mem [DEPTH];

    logic [TAW-1:0]             waddr;
    logic [TAW-1:0]             raddr0;
    logic [TAW-1:0]             raddr1;
    logic                       clamp0;
    logic                       clamp1;
    logic                       r_clamp0;
    logic                       r_clamp1;
    logic [bll_pkg::NODE_W-1:0] r_q0;
    logic [bll_pkg::NODE_W-1:0] r_q1;

    // The root reads back as its own ancestor, and any index beyond the table reads back as the root.
    always_comb begin
        clamp0 = (i_rd0.node == i_root) || (32'(i_rd0.node) >= 32'(NODES));
        clamp1 = (i_rd1.node == i_root) || (32'(i_rd1.node) >= 32'(NODES));
        waddr  = TAW'(TAW'(i_wr.node) * TAW'(LEVELS)) + TAW'(i_wr.level);
        raddr0 = clamp0 ? '0 : TAW'(TAW'(i_rd0.node) * TAW'(LEVELS)) + TAW'(i_rd0.level);
        raddr1 = clamp1 ? '0 : TAW'(TAW'(i_rd1.node) * TAW'(LEVELS)) + TAW'(i_rd1.level);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[waddr] <= i_wr.data;
        end
        r_q0     <= mem[raddr0];
        r_q1     <= mem[raddr1];
        r_clamp0 <= clamp0;
        r_clamp1 <= clamp1;
    end

    assign o_anc0 = r_clamp0 ? i_root : r_q0;
    assign o_anc1 = r_clamp1 ? i_root : r_q1;

endmodule

### rtl/binary_lifting_lca_engine.sv
`timescale 1ns / 1ps
// Binary-lifting lowest-common-ancestor engine, top level. Depends on bll_pkg, bll_if, bll_anc_table.
// Attach: one table write per level, level 0 first and then each higher level in turn.
// Query: the deeper node is lifted to the depth of the other, with one ancestor-table read per lifting
// step, then both nodes descend through the levels. One item at a time; a new transfer is taken only
// once the result is loaded into the output register. Reset and every root write start a clearing pass
// over the node memory, with no request taken; after reset the root is node 1.
module binary_lifting_lca_engine #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bll_req_if.sink    i_req,
    bll_rsp_if.source  o_rsp,
    bll_cfg_if.sink    i_cfg
);

    // Node memory entry: presence flag over the 10-bit depth.
    localparam int NAW  = $clog2(NODES);
    localparam int INFO_W = bll_pkg::NODE_W + 1;
    localparam logic [bll_pkg::LVL_W-1:0] LAST_LVL = bll_pkg::LVL_W'(LEVELS - 1);

    // Position of the highest set bit, used to pick the largest lifting jump.
    function automatic logic [bll_pkg::LVL_W-1:0] msb_pos(input logic [bll_pkg::NODE_W-1:0] v);
        logic [bll_pkg::LVL_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < bll_pkg::NODE_W; i++) begin
            if (v[i]) begin
                pos = bll_pkg::LVL_W'(i);
            end
        end
        return pos;
    endfunction

    bll_pkg::t_state r_state, n_state;

    logic [NAW-1:0]              r_clr, n_clr;
    logic [bll_pkg::NODE_W-1:0]  r_root, n_root;
    logic                        r_out_valid, n_out_valid;
    logic                        r_pend, n_pend;

    logic                        r_type, n_type;
    logic [bll_pkg::NODE_W-1:0]  r_a, n_a;
    logic [bll_pkg::NODE_W-1:0]  r_b, n_b;
    logic                        r_pres_a, n_pres_a;
    logic [bll_pkg::NODE_W-1:0]  r_dep_a, n_dep_a;
    logic [bll_pkg::NODE_W-1:0]  r_u, n_u;
    logic [bll_pkg::NODE_W-1:0]  r_v, n_v;
    logic [bll_pkg::NODE_W-1:0]  r_steps, n_steps;
    logic [bll_pkg::LVL_W-1:0]   r_k, n_k;
    logic [bll_pkg::NODE_W-1:0]  r_res, n_res;
    logic [bll_pkg::STAT_W-1:0]  r_stat, n_stat;
    logic [bll_pkg::NODE_W-1:0]  r_out_node, n_out_node;
    logic [bll_pkg::STAT_W-1:0]  r_out_stat, n_out_stat;

    // Node memory: presence and depth per node, cleared by a sweep.
    logic [INFO_W-1:0]           info_mem [NODES];
    logic [INFO_W-1:0]           r_info_q;
    logic                        info_we;
    logic [NAW-1:0]              info_waddr;
    logic [INFO_W-1:0]           info_wdata;
    logic [NAW-1:0]              info_raddr;

    // Ancestor table ports.
    bll_pkg::t_anc_wr            tbl_wr;
    bll_pkg::t_anc_rd            tbl_rd0;
    bll_pkg::t_anc_rd            tbl_rd1;
    logic [bll_pkg::NODE_W-1:0]  anc0;
    logic [bll_pkg::NODE_W-1:0]  anc1;

    // Decisions shared by the sequencer and the datapath.
    logic                        req_fire;
    logic                        cfg_fire;
    logic                        out_free;
    logic                        info_pres;
    logic [bll_pkg::NODE_W-1:0]  info_dep;
    logic                        a_in_range;
    logic                        b_in_range;
    logic                        pres_a_now;
    logic                        pres_b_now;
    logic [bll_pkg::NODE_W-1:0]  dep_b;
    logic [bll_pkg::NODE_W-1:0]  lift_u;
    logic [bll_pkg::LVL_W-1:0]   steps_msb;
    logic [bll_pkg::LVL_W-1:0]   lift_k;
    logic                        differ;
    logic [bll_pkg::NODE_W-1:0]  desc_u;
    logic [bll_pkg::NODE_W-1:0]  desc_v;
    logic                        desc_stay;
    logic                        desc_end;

    bll_anc_table #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_table (
        .i_clk  (i_clk),
        .i_root (r_root),
        .i_wr   (tbl_wr),
        .i_rd0  (tbl_rd0),
        .i_rd1  (tbl_rd1),
        .o_anc0 (anc0),
        .o_anc1 (anc1)
    );

    assign req_fire = i_req.valid && i_req.ready;
    assign cfg_fire = i_cfg.valid && i_cfg.ready;
    assign out_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        info_pres  = r_info_q[bll_pkg::NODE_W];
        info_dep   = r_info_q[bll_pkg::NODE_W-1:0];
        a_in_range = 32'(r_a) < 32'(NODES);
        b_in_range = 32'(r_b) < 32'(NODES);
        // The root is present through the register, never through the node memory.
        pres_a_now = (r_a == r_root) || (a_in_range && info_pres);
        pres_b_now = (r_b == r_root) || (b_in_range && info_pres);
        dep_b      = (r_b == r_root) ? '0 : info_dep;

        // While lifting, a pending read returns the next position of the deeper node.
        lift_u    = r_pend ? anc0 : r_u;
        steps_msb = msb_pos(r_steps);
        lift_k    = (steps_msb > LAST_LVL) ? LAST_LVL : steps_msb;

        // Both nodes jump together only where their ancestors still differ.
        // The top level repeats until the ancestors meet, which covers shallow tables.
        differ    = anc0 != anc1;
        desc_u    = (r_pend && differ) ? anc0 : r_u;
        desc_v    = (r_pend && differ) ? anc1 : r_v;
        desc_stay = differ && (r_k == LAST_LVL);
        desc_end  = !desc_stay && (r_k == '0);
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            bll_pkg::ST_CLEAR: begin
                if (r_clr == NAW'(NODES - 1)) begin
                    n_state = bll_pkg::ST_IDLE;
                end
            end
            bll_pkg::ST_IDLE: begin
                if (req_fire) begin
                    n_state = bll_pkg::ST_RDB;
                end
            end
            bll_pkg::ST_RDB: begin
                if (r_type == bll_pkg::REQ_QUERY) begin
                    n_state = bll_pkg::ST_Q_CHK;
                end else if (!a_in_range || pres_a_now) begin
                    n_state = bll_pkg::ST_DONE;
                end else begin
                    n_state = bll_pkg::ST_ATT_CHK;
                end
            end
            bll_pkg::ST_ATT_CHK: begin
                if (!pres_b_now || (LEVELS == 1)) begin
                    n_state = bll_pkg::ST_DONE;
                end else begin
                    n_state = bll_pkg::ST_ATT_FILL;
                end
            end
            bll_pkg::ST_ATT_FILL: begin
                if (r_k == LAST_LVL) begin
                    n_state = bll_pkg::ST_DONE;
                end
            end
            bll_pkg::ST_Q_CHK: begin
                if (!(r_pres_a && pres_b_now)) begin
                    n_state = bll_pkg::ST_DONE;
                end else begin
                    n_state = bll_pkg::ST_Q_LIFT;
                end
            end
            bll_pkg::ST_Q_LIFT: begin
                if (r_steps == '0) begin
                    n_state = bll_pkg::ST_Q_DESC;
                end
            end
            bll_pkg::ST_Q_DESC: begin
                if (!r_pend) begin
                    if (r_u == r_v) begin
                        n_state = bll_pkg::ST_DONE;
                    end
                end else if (desc_end) begin
                    n_state = bll_pkg::ST_Q_FIN;
                end
            end
            bll_pkg::ST_Q_FIN: begin
                n_state = bll_pkg::ST_DONE;
            end
            bll_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = bll_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bll_pkg::ST_CLEAR;
            end
        endcase
        // A root write starts a fresh tree: the presence map is swept clear again.
        if (cfg_fire) begin
            n_state = bll_pkg::ST_CLEAR;
        end
    end

    // Datapath and memory requests for each state.
    always_comb begin
        n_clr       = r_clr;
        n_root      = r_root;
        n_pend      = r_pend;
        n_type      = r_type;
        n_a         = r_a;
        n_b         = r_b;
        n_pres_a    = r_pres_a;
        n_dep_a     = r_dep_a;
        n_u         = r_u;
        n_v         = r_v;
        n_steps     = r_steps;
        n_k         = r_k;
        n_res       = r_res;
        n_stat      = r_stat;
        n_out_node  = r_out_node;
        n_out_stat  = r_out_stat;
        n_out_valid = r_out_valid && !o_rsp.ready;

        info_we    = 1'b0;
        info_waddr = NAW'(r_a);
        info_wdata = '0;
        info_raddr = NAW'(r_b);

        tbl_wr.en    = 1'b0;
        tbl_wr.node  = r_a;
        tbl_wr.level = r_k;
        tbl_wr.data  = anc0;
        tbl_rd0.node  = r_u;
        tbl_rd0.level = r_k;
        tbl_rd1.node  = r_v;
        tbl_rd1.level = r_k;

        case (r_state)
            bll_pkg::ST_CLEAR: begin
                info_we    = 1'b1;
                info_waddr = r_clr;
                info_wdata = '0;
                n_clr      = r_clr + NAW'(1);
            end
            bll_pkg::ST_IDLE: begin
                info_raddr = NAW'(i_req.node_a);
                if (req_fire) begin
                    n_type = i_req.req_type;
                    n_a    = i_req.node_a;
                    n_b    = i_req.node_b;
                    n_pend = 1'b0;
                    n_res  = '0;
                    n_stat = bll_pkg::STAT_OK;
                end
            end
            bll_pkg::ST_RDB: begin
                info_raddr = NAW'(r_b);
                n_pres_a   = pres_a_now;
                n_dep_a    = (r_a == r_root) ? '0 : info_dep;
                if (r_type == bll_pkg::REQ_ATTACH) begin
                    if (!a_in_range) begin
                        n_stat = bll_pkg::STAT_ABSENT;
                    end else if (pres_a_now) begin
                        n_stat = bll_pkg::STAT_DUPLICATE;
                    end
                end
            end
            bll_pkg::ST_ATT_CHK: begin
                if (!pres_b_now) begin
                    n_stat = bll_pkg::STAT_ABSENT;
                end else begin
                    info_we      = 1'b1;
                    info_waddr   = NAW'(r_a);
                    info_wdata   = {1'b1, (dep_b == bll_pkg::DEPTH_MAX) ?
                                          bll_pkg::DEPTH_MAX : dep_b + 10'd1};
                    tbl_wr.en    = 1'b1;
                    tbl_wr.level = '0;
                    tbl_wr.data  = r_b;
                    tbl_rd0.node  = r_b;
                    tbl_rd0.level = '0;
                    n_k          = bll_pkg::LVL_W'(1);
                end
            end
            bll_pkg::ST_ATT_FILL: begin
                // Level k of the new node is level k-1 of its level k-1 ancestor.
                tbl_wr.en     = 1'b1;
                tbl_rd0.node  = anc0;
                tbl_rd0.level = r_k;
                n_k           = r_k + bll_pkg::LVL_W'(1);
            end
            bll_pkg::ST_Q_CHK: begin
                n_pend = 1'b0;
                if (!(r_pres_a && pres_b_now)) begin
                    n_stat = bll_pkg::STAT_ABSENT;
                end else if (r_dep_a < dep_b) begin
                    n_u     = r_b;
                    n_v     = r_a;
                    n_steps = dep_b - r_dep_a;
                end else begin
                    n_u     = r_a;
                    n_v     = r_b;
                    n_steps = r_dep_a - dep_b;
                end
            end
            bll_pkg::ST_Q_LIFT: begin
                n_u = lift_u;
                n_k = LAST_LVL;
                tbl_rd0.node  = lift_u;
                tbl_rd0.level = lift_k;
                if (r_steps != '0) begin
                    n_steps = r_steps - (10'd1 << lift_k);
                    n_pend  = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
            end
            bll_pkg::ST_Q_DESC: begin
                n_u = desc_u;
                n_v = desc_v;
                if (!r_pend) begin
                    if (r_u == r_v) begin
                        n_res = r_u;
                    end else begin
                        n_pend = 1'b1;
                    end
                end else if (desc_end) begin
                    // Final step to the parent of the lifted node.
                    tbl_rd0.node  = desc_u;
                    tbl_rd0.level = '0;
                end else begin
                    tbl_rd0.node  = desc_u;
                    tbl_rd1.node  = desc_v;
                    tbl_rd0.level = desc_stay ? r_k : r_k - bll_pkg::LVL_W'(1);
                    tbl_rd1.level = desc_stay ? r_k : r_k - bll_pkg::LVL_W'(1);
                    n_k           = desc_stay ? r_k : r_k - bll_pkg::LVL_W'(1);
                end
            end
            bll_pkg::ST_Q_FIN: begin
                n_res = anc0;
            end
            bll_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_node  = r_res;
                    n_out_stat  = r_stat;
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase

        if (cfg_fire) begin
            n_root = i_cfg.root_node;
            n_clr  = '0;
        end
    end

    // Handshake and result outputs.
    always_comb begin
        i_req.ready         = (r_state == bll_pkg::ST_IDLE);
        i_cfg.ready         = 1'b1;
        o_rsp.valid         = r_out_valid;
        o_rsp.ancestor_node = r_out_node;
        o_rsp.status        = r_out_stat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bll_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_root      <= bll_pkg::ROOT_RESET;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_root      <= n_root;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type     <= n_type;
        r_a        <= n_a;
        r_b        <= n_b;
        r_pres_a   <= n_pres_a;
        r_dep_a    <= n_dep_a;
        r_u        <= n_u;
        r_v        <= n_v;
        r_steps    <= n_steps;
        r_k        <= n_k;
        r_res      <= n_res;
        r_stat     <= n_stat;
        r_out_node <= n_out_node;
        r_out_stat <= n_out_stat;
    end

    always_ff @(posedge i_clk) begin
        if (info_we) begin
            info_mem[info_waddr] <= info_wdata;
        end
        r_info_q <= info_mem[info_raddr];
    end

    // The ancestor table is written only while a node is being attached.
    a_wr_only_attach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_wr.en |-> (r_state == bll_pkg::ST_ATT_CHK || r_state == bll_pkg::ST_ATT_FILL))
        else $error("ancestor table written outside attach");

    // An error result never carries an ancestor.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != bll_pkg::STAT_OK) |-> (o_rsp.ancestor_node == '0))
        else $error("error result with nonzero ancestor");

    // Every lifting step strictly reduces the remaining depth difference.
    a_lift_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bll_pkg::ST_Q_LIFT && r_steps != '0 && !cfg_fire)
        |=> (r_steps < $past(r_steps)))
        else $error("lifting step did not reduce the depth difference");

    // A finished item reaches the output register once it is free.
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bll_pkg::ST_DONE && out_free) |=> o_rsp.valid)
        else $error("finished result not loaded");

    // The descending pass never addresses a level beyond the table.
    a_desc_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bll_pkg::ST_Q_DESC) |-> (r_k <= LAST_LVL))
        else $error("descending pass level out of range");

endmodule
